// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Condition must never hold.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== src/lcf_pkg.sv =====
package lcf_pkg;

	localparam int SENSOR_MAX  = 4;
	localparam int TX_LEN      = 9;
	localparam int QUEUE_DEPTH = 2;

	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_BYTE = 1'b1;

	localparam logic [7:0] SUM_GOOD   = 8'hFF;
	localparam logic [7:0] SYNC_A     = 8'h5A;
	localparam logic [7:0] SYNC_B     = 8'hA5;
	localparam logic [7:0] RUN_BYTE   = 8'd8;
	localparam logic [7:0] CNT_MAX    = 8'hFF;

	localparam logic [15:0] BTN_TH_OK     = 16'd1023;
	localparam logic [15:0] BTN_TH_CANCEL = 16'd720;
	localparam logic [15:0] BTN_TH_RIGHT  = 16'd270;
	localparam logic [15:0] BTN_TH_LEFT   = 16'd60;

	localparam logic [11:0] BATT_SCALE = 12'd3545;
	localparam int          BATT_SHIFT = 9;

	typedef enum logic [2:0] {
		LM_UNINIT,
		LM_DOWN,
		LM_HANDSHAKE,
		LM_WAIT1,
		LM_WAIT2,
		LM_SEND,
		LM_RECEIVE
	} link_mode_t;

	typedef enum logic [2:0] {
		CMD_STATE,
		CMD_HANDSHAKE,
		CMD_READ,
		CMD_FRAME,
		CMD_REPORT
	} command_t;

	typedef enum logic [2:0] {
		REG_LINK_ENABLE,
		REG_POWER_REQUEST,
		REG_MOTOR_A_SPEED,
		REG_MOTOR_B_SPEED,
		REG_MOTOR_C_SPEED,
		REG_BRAKE_MASK,
		REG_FAIL_LIMIT
	} reg_index_t;

	typedef enum logic [1:0] {
		PWR_RUN,
		PWR_OFF,
		PWR_BOOT
	} power_t;

	typedef enum logic [2:0] {
		BTN_NONE,
		BTN_LEFT,
		BTN_RIGHT,
		BTN_CANCEL,
		BTN_OK
	} button_t;

	typedef enum logic [1:0] {
		BK_START,
		BK_REPORT,
		BK_FRAME
	} back_state_t;

	typedef struct packed {
		logic       kind;
		logic       bus_ready;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		command_t    command;
		logic [7:0]  frame_byte;
		logic [1:0]  sensor_index;
		logic [15:0] sensor_value;
		button_t     button_code;
		logic [12:0] battery_mv;
		logic        supply_is_aa;
		logic [1:0]  version_major;
		logic [2:0]  version_minor;
		link_mode_t  link_state;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic              link_enable;
		logic [1:0]        power_request;
		logic signed [7:0] motor_a_speed;
		logic signed [7:0] motor_b_speed;
		logic signed [7:0] motor_c_speed;
		logic [2:0]        brake_mask;
		logic [7:0]        fail_limit;
	} cfg_t;

	// One queued job: either a single result or reports and/or a command frame.
	typedef struct packed {
		logic                         single;
		command_t                     cmd;
		logic                         reports;
		logic                         frame;
		link_mode_t                   state;
		logic [SENSOR_MAX-1:0][15:0]  sensor;
		button_t                      button;
		logic [12:0]                  mv;
		logic                         supply;
		logic [1:0]                   major;
		logic [2:0]                   minor;
	} job_t;

endpackage

// ===== src/lcf_front.sv =====
module lcf_front import lcf_pkg::*; #(
	parameter int SENSOR_COUNT = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  in_item_t item,
	input  cfg_t     cfg,
	output logic     push,
	output job_t     job
);

	localparam int RX_LEN = 2 * SENSOR_COUNT + 5;
	localparam int PW     = $clog2(RX_LEN + 1);
	localparam int BW_POS = 2 * SENSOR_COUNT;
	localparam int ST_POS = BW_POS + 2;

	link_mode_t     mode_q, mode_d;
	logic [7:0]     cnt_q, cnt_d;
	logic [PW-1:0]  pos_q, pos_d;
	logic [7:0]     sum_q, sum_d;
	logic [7:0]     rxb_q [RX_LEN];
	logic           clear, wr;

	logic           good, restart;
	logic [7:0]     cnt_bad, cnt_rx;
	logic [15:0]    bw, st;
	logic [21:0]    prod;
	button_t        btn;

	always_comb begin
		good    = (sum_q == SUM_GOOD);
		cnt_bad = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 8'd1;
		cnt_rx  = good ? 8'd0 : cnt_bad;
		restart = (cnt_rx >= cfg.fail_limit);

		bw   = {rxb_q[BW_POS + 1], rxb_q[BW_POS]};
		st   = {rxb_q[ST_POS + 1], rxb_q[ST_POS]};
		prod = {12'd0, st[9:0]} * {10'd0, BATT_SCALE};

		priority if (bw > BTN_TH_OK)
			btn = BTN_OK;
		else if (bw > BTN_TH_CANCEL)
			btn = BTN_CANCEL;
		else if (bw > BTN_TH_RIGHT)
			btn = BTN_RIGHT;
		else if (bw > BTN_TH_LEFT)
			btn = BTN_LEFT;
		else
			btn = BTN_NONE;
	end

	always_comb begin
		mode_d = mode_q;
		cnt_d  = cnt_q;
		pos_d  = pos_q;
		sum_d  = sum_q;
		clear  = 1'b0;
		wr     = 1'b0;

		job        = '0;
		job.single = 1'b1;
		job.cmd    = CMD_STATE;
		for (int i = 0; i < SENSOR_COUNT; i++)
			job.sensor[i] = {rxb_q[2 * i + 1], rxb_q[2 * i]};
		job.button = btn;
		job.mv     = prod[BATT_SHIFT +: 13];
		job.supply = st[15];
		job.major  = st[14:13];
		job.minor  = st[12:10];

		if (accept) begin
			if (item.kind == KIND_BYTE) begin
				// drop bytes outside the receive state or past a full frame
				if (mode_q == LM_RECEIVE && pos_q < PW'(RX_LEN)) begin
					wr    = 1'b1;
					pos_d = pos_q + PW'(1);
					sum_d = sum_q + item.rx_byte;
				end
			end else begin
				unique case (mode_q)
					LM_UNINIT: begin
						if (cfg.link_enable)
							mode_d = LM_DOWN;
					end
					LM_DOWN: begin
						job.cmd = CMD_HANDSHAKE;
						cnt_d   = 8'd0;
						mode_d  = LM_HANDSHAKE;
					end
					LM_HANDSHAKE: begin
						if (item.bus_ready)
							mode_d = LM_WAIT1;
					end
					LM_WAIT1: mode_d = LM_WAIT2;
					LM_WAIT2: mode_d = LM_SEND;
					LM_SEND: begin
						if (item.bus_ready) begin
							mode_d  = LM_RECEIVE;
							clear   = 1'b1;
							pos_d   = '0;
							sum_d   = 8'd0;
							job.cmd = CMD_READ;
						end
					end
					LM_RECEIVE: begin
						if (item.bus_ready) begin
							cnt_d       = cnt_rx;
							job.reports = good;
							job.frame   = !restart;
							job.single  = !good && restart;
							mode_d      = restart ? LM_DOWN : LM_SEND;
						end
					end
					default: mode_d = LM_UNINIT;
				endcase
			end
		end
		job.state = mode_d;
	end

	assign push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= LM_UNINIT;
			cnt_q  <= 8'd0;
			pos_q  <= '0;
			sum_q  <= 8'd0;
			for (int j = 0; j < RX_LEN; j++)
				rxb_q[j] <= 8'd0;
		end else begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			pos_q  <= pos_d;
			sum_q  <= sum_d;
			for (int j = 0; j < RX_LEN; j++) begin
				if (clear)
					rxb_q[j] <= 8'd0;
				else if (wr && pos_q == PW'(j))
					rxb_q[j] <= item.rx_byte;
			end
		end
	end

endmodule

// ===== src/lcf_queue.sv =====
module lcf_queue import lcf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t din,
	input  logic pop,
	output job_t dout,
	output logic valid,
	output logic full
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	job_t          mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign valid = (cnt_q != '0);
	assign full  = (cnt_q == CW'(QUEUE_DEPTH));
	assign dout  = mem_q[rd_q];

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= bump(wr_q);
			if (pop)
				rd_q <= bump(rd_q);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

endmodule

// ===== src/lcf_back.sv =====
module lcf_back import lcf_pkg::*; #(
	parameter int SENSOR_COUNT = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  job_t      job,
	input  logic      job_valid,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	back_state_t bk_q, bk_d;
	logic [3:0]  cnt_q, cnt_d;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        load, step, first, do_single, do_report, last_rep, is_last;
	logic [3:0]  idx;
	logic [7:0]  f0, f1, fsum, fb;
	out_item_t   res;

	always_comb begin
		unique case (cfg.power_request)
			PWR_RUN:  begin f0 = 8'd0;   f1 = RUN_BYTE; end
			PWR_OFF:  begin f0 = SYNC_A; f1 = 8'd0;     end
			PWR_BOOT: begin f0 = SYNC_A; f1 = SYNC_B;   end
			default:  begin f0 = 8'd0;   f1 = 8'd0;     end
		endcase
		fsum = f0 + f1 + cfg.motor_a_speed + cfg.motor_b_speed + cfg.motor_c_speed
			+ {5'd0, cfg.brake_mask};

		unique case (idx)
			4'd0:    fb = f0;
			4'd1:    fb = f1;
			4'd2:    fb = cfg.motor_a_speed;
			4'd3:    fb = cfg.motor_b_speed;
			4'd4:    fb = cfg.motor_c_speed;
			4'd6:    fb = {5'd0, cfg.brake_mask};
			4'd8:    fb = ~fsum;
			default: fb = 8'd0;
		endcase
	end

	always_comb begin
		load      = !out_valid_q || out_ready;
		step      = job_valid && load;
		first     = (bk_q == BK_START);
		do_single = first && job.single;
		do_report = first ? (!job.single && job.reports) : (bk_q == BK_REPORT);
		idx       = first ? 4'd0 : cnt_q;
		last_rep  = (idx == 4'(SENSOR_COUNT - 1));
		if (do_single)
			is_last = 1'b1;
		else if (do_report)
			is_last = last_rep && !job.frame;
		else
			is_last = (idx == 4'(TX_LEN - 1));

		res            = '0;
		res.link_state = job.state;
		res.last       = is_last;
		if (do_single) begin
			res.command = job.cmd;
		end else if (do_report) begin
			res.command       = CMD_REPORT;
			res.sensor_index  = idx[1:0];
			res.sensor_value  = job.sensor[idx[1:0]];
			res.button_code   = job.button;
			res.battery_mv    = job.mv;
			res.supply_is_aa  = job.supply;
			res.version_major = job.major;
			res.version_minor = job.minor;
		end else begin
			res.command    = CMD_FRAME;
			res.frame_byte = fb;
		end

		bk_d  = bk_q;
		cnt_d = cnt_q;
		if (step) begin
			priority if (is_last) begin
				bk_d  = BK_START;
				cnt_d = 4'd0;
			end else if (do_report && last_rep) begin
				bk_d  = BK_FRAME;
				cnt_d = 4'd0;
			end else begin
				bk_d  = do_report ? BK_REPORT : BK_FRAME;
				cnt_d = idx + 4'd1;
			end
		end
		pop = step && is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bk_q        <= BK_START;
			cnt_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			bk_q  <= bk_d;
			cnt_q <= cnt_d;
			if (step)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== src/coprocessor_link_frame_engine.sv =====
// Link controller for a motor/sensor coprocessor. The front accepts one item
// (tick or received byte) per cycle whenever its two-entry job queue has room,
// updates the link state and receive buffer, and queues one job. The back
// expands each job into its results at one result per cycle while out_ready
// is high: one result for most items, up to 13 (sensor reports then a 9-byte
// command frame) for a tick that completes a receive. The back's result
// sequencer sets the sustained rate, one to 13 results per item. The checksum is
// kept as a running byte sum while bytes arrive. Configuration writes are
// always ready; write them only while no item is in flight.
`include "assert_macros.svh"

module coprocessor_link_frame_engine import lcf_pkg::*; #(
	parameter int SENSOR_COUNT = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam cfg_t CFG_RESET = '{
		link_enable:   1'b0,
		power_request: 2'd0,
		motor_a_speed: 8'sd0,
		motor_b_speed: 8'sd0,
		motor_c_speed: 8'sd0,
		brake_mask:    3'd0,
		fail_limit:    8'd3
	};

	cfg_t cfg_q;
	logic accept, push, pop, q_valid, q_full;
	job_t front_job, head_job;
	logic frame_seen, report_seen, hs_seen, report_state_ok, hs_ok;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid) begin
			unique case (reg_index_t'(cfg_index))
				REG_LINK_ENABLE:   cfg_q.link_enable   <= cfg_data[0];
				REG_POWER_REQUEST: cfg_q.power_request <= cfg_data[1:0];
				REG_MOTOR_A_SPEED: cfg_q.motor_a_speed <= cfg_data;
				REG_MOTOR_B_SPEED: cfg_q.motor_b_speed <= cfg_data;
				REG_MOTOR_C_SPEED: cfg_q.motor_c_speed <= cfg_data;
				REG_BRAKE_MASK:    cfg_q.brake_mask    <= cfg_data[2:0];
				REG_FAIL_LIMIT:    cfg_q.fail_limit    <= cfg_data;
				default: ;
			endcase
		end
	end

	lcf_front #(.SENSOR_COUNT(SENSOR_COUNT)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (in_data),
		.cfg    (cfg_q),
		.push   (push),
		.job    (front_job)
	);

	lcf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_job),
		.pop    (pop),
		.dout   (head_job),
		.valid  (q_valid),
		.full   (q_full)
	);

	lcf_back #(.SENSOR_COUNT(SENSOR_COUNT)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job       (head_job),
		.job_valid (q_valid),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign frame_seen      = out_valid && out_data.command == CMD_FRAME;
	assign report_seen     = out_valid && out_data.command == CMD_REPORT;
	assign hs_seen         = out_valid && out_data.command == CMD_HANDSHAKE;
	assign report_state_ok = out_data.link_state == LM_SEND || out_data.link_state == LM_DOWN;
	assign hs_ok           = out_data.last && out_data.link_state == LM_HANDSHAKE;

	`ASSERT_IMPLY(a_frame_in_send, clk, arst_n, frame_seen, out_data.link_state == LM_SEND)
	`ASSERT_IMPLY(a_report_state, clk, arst_n, report_seen, report_state_ok)
	`ASSERT_IMPLY(a_handshake_last, clk, arst_n, hs_seen, hs_ok)
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && !q_valid)

endmodule

// ===== test/coprocessor_link_frame_engine_tb.sv =====
module coprocessor_link_frame_engine_tb;
	import lcf_pkg::*;

	localparam int RX_BYTES = 2 * SENSOR_MAX + 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 58;
	// power request code with no name in the package: sync bytes both zero
	localparam logic [1:0] PWR_NONE = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	coprocessor_link_frame_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// shadow of the link controller
	link_mode_t mode_now;
	logic [7:0] bad_sums;
	logic [7:0] rx_buf [RX_BYTES];
	int rx_pos;
	cfg_t regs;

	in_item_t items_waiting [$];
	out_item_t results_due [$];
	int items_planned = 0;
	int misses = 0;
	int unsigned cycles = 0;
	bit calm = 1'b0;
	int in_hold = 0;
	int out_hold = 0;
	int out_draw;

	function automatic int gap_draw();
		return calm ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic out_item_t blank(command_t c);
		out_item_t r;
		r = '0;
		r.command = c;
		return r;
	endfunction

	function automatic void link_step(in_item_t it);
		out_item_t batch [$];
		out_item_t r;
		logic [7:0] sum;
		logic [15:0] bw;
		logic [15:0] st;
		logic [23:0] prod;
		button_t btn;
		logic [TX_LEN-1:0][7:0] f;
		int i;
		if (it.kind == KIND_BYTE) begin
			if (mode_now == LM_RECEIVE && rx_pos < RX_BYTES) begin
				rx_buf[rx_pos] = it.rx_byte;
				rx_pos++;
			end
		end else begin
			case (mode_now)
				LM_UNINIT: begin
					if (regs.link_enable) mode_now = LM_DOWN;
				end
				LM_DOWN: begin
					batch.push_back(blank(CMD_HANDSHAKE));
					bad_sums = '0;
					mode_now = LM_HANDSHAKE;
				end
				LM_HANDSHAKE: begin
					if (it.bus_ready) mode_now = LM_WAIT1;
				end
				LM_WAIT1: mode_now = LM_WAIT2;
				LM_WAIT2: mode_now = LM_SEND;
				LM_SEND: begin
					if (it.bus_ready) begin
						mode_now = LM_RECEIVE;
						for (i = 0; i < RX_BYTES; i++)
							rx_buf[i] = '0;
						rx_pos = 0;
						batch.push_back(blank(CMD_READ));
					end
				end
				LM_RECEIVE: begin
					if (it.bus_ready) begin
						sum = '0;
						for (i = 0; i < RX_BYTES; i++)
							sum += rx_buf[i];
						if (sum != SUM_GOOD) begin
							if (bad_sums != CNT_MAX) bad_sums++;
						end else begin
							bad_sums = '0;
							bw = {rx_buf[2*SENSOR_MAX+1], rx_buf[2*SENSOR_MAX]};
							st = {rx_buf[2*SENSOR_MAX+3], rx_buf[2*SENSOR_MAX+2]};
							if (bw > BTN_TH_OK) btn = BTN_OK;
							else if (bw > BTN_TH_CANCEL) btn = BTN_CANCEL;
							else if (bw > BTN_TH_RIGHT) btn = BTN_RIGHT;
							else if (bw > BTN_TH_LEFT) btn = BTN_LEFT;
							else btn = BTN_NONE;
							prod = st[9:0] * BATT_SCALE;
							for (i = 0; i < SENSOR_MAX; i++) begin
								r = blank(CMD_REPORT);
								r.sensor_index = 2'(i);
								r.sensor_value = {rx_buf[2*i+1], rx_buf[2*i]};
								r.button_code = btn;
								r.battery_mv = 13'(prod >> BATT_SHIFT);
								r.supply_is_aa = st[15];
								r.version_major = st[14:13];
								r.version_minor = st[12:10];
								batch.push_back(r);
							end
						end
						if (bad_sums >= regs.fail_limit) begin
							mode_now = LM_DOWN;
						end else begin
							mode_now = LM_SEND;
							f = '0;
							case (regs.power_request)
								PWR_RUN: f[1] = RUN_BYTE;
								PWR_OFF: f[0] = SYNC_A;
								PWR_BOOT: begin
									f[0] = SYNC_A;
									f[1] = SYNC_B;
								end
								default: ;
							endcase
							f[2] = regs.motor_a_speed;
							f[3] = regs.motor_b_speed;
							f[4] = regs.motor_c_speed;
							f[6] = {5'b0, regs.brake_mask};
							sum = '0;
							for (i = 0; i < TX_LEN - 1; i++)
								sum += f[i];
							f[TX_LEN-1] = ~sum;
							for (i = 0; i < TX_LEN; i++) begin
								r = blank(CMD_FRAME);
								r.frame_byte = f[i];
								batch.push_back(r);
							end
						end
					end
				end
				default: mode_now = LM_UNINIT;
			endcase
		end
		if (batch.size() == 0)
			batch.push_back(blank(CMD_STATE));
		for (i = 0; i < batch.size(); i++) begin
			r = batch[i];
			r.link_state = mode_now;
			r.last = (i == batch.size() - 1);
			results_due.push_back(r);
		end
	endfunction

	task automatic note_miss(string what, out_item_t want, out_item_t got);
		misses++;
		if (misses <= 10)
			$display("mismatch in %s: expected %h, got %h", what, want, got);
	endtask

	task automatic check_result(out_item_t got);
		out_item_t want;
		string fld;
		if (results_due.size() == 0) begin
			note_miss("unexpected result", '0, got);
			return;
		end
		want = results_due.pop_front();
		fld = "";
		if (got.command !== want.command) fld = "command";
		else if (got.frame_byte !== want.frame_byte) fld = "frame_byte";
		else if (got.sensor_index !== want.sensor_index) fld = "sensor_index";
		else if (got.sensor_value !== want.sensor_value) fld = "sensor_value";
		else if (got.button_code !== want.button_code) fld = "button_code";
		else if (got.battery_mv !== want.battery_mv) fld = "battery_mv";
		else if (got.supply_is_aa !== want.supply_is_aa) fld = "supply_is_aa";
		else if (got.version_major !== want.version_major) fld = "version_major";
		else if (got.version_minor !== want.version_minor) fld = "version_minor";
		else if (got.link_state !== want.link_state) fld = "link_state";
		else if (got.last !== want.last) fld = "last";
		if (fld != "")
			note_miss(fld, want, got);
	endtask

	// input driver: hold each item until taken, then idle for the drawn gap
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				link_step(in_data);
			if (in_valid && !in_ready) begin
			end else if (in_hold > 0) begin
				in_hold <= in_hold - 1;
				in_valid <= 1'b0;
			end else if (items_waiting.size() > 0) begin
				in_data <= items_waiting.pop_front();
				in_valid <= 1'b1;
				in_hold <= gap_draw();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor: stall for the drawn number of cycles after each item
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				check_result(out_data);
				out_draw = gap_draw();
				out_ready <= (out_draw == 0);
				out_hold <= (out_draw == 0) ? 0 : out_draw - 1;
			end else if (out_hold > 0) begin
				out_hold <= out_hold - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[coprocessor_link_frame_engine] ERROR");
			$finish;
		end
	end

	task automatic push_item(logic kind, logic rdy, logic [7:0] b);
		in_item_t it;
		it.kind = kind;
		it.bus_ready = rdy;
		it.rx_byte = b;
		items_waiting.push_back(it);
		items_planned++;
	endtask

	task automatic push_tick(logic rdy);
		push_item(KIND_TICK, rdy, 8'($urandom_range(0, 255)));
	endtask

	// sensor words, button word, status word, then the checksum byte
	task automatic push_frame(logic [5:0][15:0] w, bit good);
		logic [7:0] sum;
		int i;
		sum = '0;
		for (i = 0; i < 6; i++) begin
			push_item(KIND_BYTE, 1'($urandom_range(0, 1)), w[i][7:0]);
			push_item(KIND_BYTE, 1'($urandom_range(0, 1)), w[i][15:8]);
			sum += w[i][7:0] + w[i][15:8];
		end
		if (good)
			push_item(KIND_BYTE, 1'($urandom_range(0, 1)), SUM_GOOD - sum);
		else
			push_item(KIND_BYTE, 1'($urandom_range(0, 1)),
				SUM_GOOD - sum + 8'($urandom_range(1, 255)));
	endtask

	task automatic push_rx_frame();
		logic [5:0][15:0] w;
		int i;
		int shape;
		int n;
		for (i = 0; i < SENSOR_MAX; i++) begin
			case ($urandom_range(0, 9))
				0: w[i] = 16'h0000;
				1: w[i] = 16'hFFFF;
				default: w[i] = 16'($urandom_range(0, 65535));
			endcase
		end
		// button word around each threshold
		case ($urandom_range(0, 10))
			0: w[4] = 16'd0;
			1: w[4] = BTN_TH_LEFT;
			2: w[4] = BTN_TH_LEFT + 16'd1;
			3: w[4] = BTN_TH_RIGHT;
			4: w[4] = BTN_TH_RIGHT + 16'd1;
			5: w[4] = BTN_TH_CANCEL;
			6: w[4] = BTN_TH_CANCEL + 16'd1;
			7: w[4] = BTN_TH_OK;
			8: w[4] = BTN_TH_OK + 16'd1;
			9: w[4] = 16'hFFFF;
			default: w[4] = 16'($urandom_range(0, 65535));
		endcase
		w[5] = 16'($urandom_range(0, 65535));
		shape = $urandom_range(0, 9);
		if (shape <= 6) begin
			push_frame(w, 1'b1);
		end else if (shape == 7) begin
			push_frame(w, 1'b0);
		end else if (shape == 8) begin
			// short frame: the tail stays cleared
			n = $urandom_range(0, RX_BYTES - 1);
			for (i = 0; i < n; i++)
				push_item(KIND_BYTE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		end else begin
			// extra bytes past a full frame are dropped
			push_frame(w, 1'b1);
			n = $urandom_range(1, 3);
			for (i = 0; i < n; i++)
				push_item(KIND_BYTE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic plan_chunk();
		calm = ($urandom_range(0, 5) == 0);
		if ($urandom_range(0, 99) < 8) begin
			push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				8'($urandom_range(0, 255)));
		end else begin
			case (mode_now)
				LM_SEND: begin
					if ($urandom_range(0, 4) == 0) push_tick(1'b0);
					push_tick(1'b1);
					push_rx_frame();
					if ($urandom_range(0, 4) == 0) push_tick(1'b0);
					push_tick(1'b1);
				end
				LM_RECEIVE: begin
					push_rx_frame();
					push_tick(1'b1);
				end
				default: push_tick($urandom_range(0, 3) != 0);
			endcase
		end
	endtask

	task automatic wait_accepted();
		do @(negedge clk); while (items_waiting.size() != 0 || in_valid);
	endtask

	task automatic wait_idle();
		wait_accepted();
		while (results_due.size() != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(reg_index_t idx, logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LINK_ENABLE: regs.link_enable = val[0];
			REG_POWER_REQUEST: regs.power_request = val[1:0];
			REG_MOTOR_A_SPEED: regs.motor_a_speed = val;
			REG_MOTOR_B_SPEED: regs.motor_b_speed = val;
			REG_MOTOR_C_SPEED: regs.motor_c_speed = val;
			REG_BRAKE_MASK: regs.brake_mask = val[2:0];
			REG_FAIL_LIMIT: regs.fail_limit = val;
			default: ;
		endcase
	endtask

	task automatic set_config(logic en, logic [1:0] pwr, logic [7:0] a, logic [7:0] b,
			logic [7:0] c, logic [2:0] brk, logic [7:0] lim);
		write_cfg(REG_LINK_ENABLE, {7'b0, en});
		write_cfg(REG_POWER_REQUEST, {6'b0, pwr});
		write_cfg(REG_MOTOR_A_SPEED, a);
		write_cfg(REG_MOTOR_B_SPEED, b);
		write_cfg(REG_MOTOR_C_SPEED, c);
		write_cfg(REG_BRAKE_MASK, {5'b0, brk});
		write_cfg(REG_FAIL_LIMIT, lim);
		@(negedge clk);
	endtask

	initial begin
		int ph;
		int goal;
		logic [5:0][15:0] w;
		int i;
		mode_now = LM_UNINIT;
		bad_sums = '0;
		rx_pos = 0;
		for (i = 0; i < RX_BYTES; i++)
			rx_buf[i] = '0;
		regs = '0;
		regs.fail_limit = 8'd3;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// disabled link stays put; a byte there is dropped
		write_cfg(REG_LINK_ENABLE, 8'd0);
		@(negedge clk);
		push_tick(1'b1);
		push_item(KIND_BYTE, 1'b1, 8'hFF);
		wait_idle();
		write_cfg(REG_LINK_ENABLE, 8'd1);
		@(negedge clk);
		calm = 1'b1;
		push_tick(1'b0);
		push_tick(1'b0);
		push_tick(1'b0);
		push_tick(1'b1);
		push_tick(1'b0);
		push_tick(1'b1);
		push_tick(1'b0);
		push_tick(1'b1);
		w[0] = 16'hFFFF;
		w[1] = 16'h0000;
		w[2] = 16'h8001;
		w[3] = 16'h7FFE;
		w[4] = BTN_TH_OK + 16'd1;
		w[5] = 16'hFFFF;
		push_frame(w, 1'b1);
		push_item(KIND_BYTE, 1'b0, 8'h00);
		push_tick(1'b0);
		push_tick(1'b1);

		for (ph = 0; ph < 5; ph++) begin
			wait_idle();
			case (ph)
				0: set_config(1'b1, PWR_RUN, 8'h7F, 8'h80, 8'h00, 3'd7, 8'd255);
				1: set_config(1'b1, PWR_OFF, 8'h80, 8'h7F, 8'hFF, 3'd0, 8'd1);
				2: set_config(1'b1, PWR_BOOT, 8'h00, 8'h00, 8'h00, 3'd5, 8'd0);
				3: set_config(1'b0, PWR_NONE, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					3'($urandom_range(0, 7)), 8'($urandom_range(1, 4)));
				default: set_config(1'b1, 2'($urandom_range(0, 3)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
					8'($urandom_range(0, 255)));
			endcase
			goal = items_planned + PHASE_ITEMS;
			while (items_planned < goal) begin
				wait_accepted();
				plan_chunk();
			end
		end

		wait_idle();
		repeat (30) @(posedge clk);
		misses += results_due.size();
		if (misses == 0)
			$display("[coprocessor_link_frame_engine] OK");
		else
			$display("[coprocessor_link_frame_engine] ERROR");
		$finish;
	end

endmodule
